// ===== rtl/lptc_pkg.sv =====
`default_nettype none

package lptc_pkg;

	localparam int ENTRIES  = 8;
	localparam int TAG_BITS = 16;
	localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AGE_BITS = IDX_BITS;
	localparam int PAGE_BITS = 16;
	localparam int SLOT_BITS = 3;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [IDX_BITS-1:0] idx_t;
	typedef logic [AGE_BITS-1:0] age_t;

	typedef struct packed {
		logic valid;
		logic opcode;
		tag_t tag;
	} dir_req_t;

	typedef struct packed {
		logic hit;
		idx_t slot;
		logic ev_valid;
		tag_t ev_tag;
	} dir_res_t;

	// Low TAG_BITS bits of a page number, zero-extended when the tag is wider.
	function automatic tag_t page_to_tag(input logic [PAGE_BITS-1:0] page);
		logic [TAG_BITS+PAGE_BITS-1:0] w;
		begin
			w = {{TAG_BITS{1'b0}}, page};
			page_to_tag = w[TAG_BITS-1:0];
		end
	endfunction

	function automatic logic [PAGE_BITS-1:0] tag_to_page(input tag_t tag);
		logic [TAG_BITS+PAGE_BITS-1:0] w;
		begin
			w = {{PAGE_BITS{1'b0}}, tag};
			tag_to_page = w[PAGE_BITS-1:0];
		end
	endfunction

	function automatic logic [SLOT_BITS-1:0] idx_to_slot(input idx_t idx);
		logic [IDX_BITS+SLOT_BITS-1:0] w;
		begin
			w = {{SLOT_BITS{1'b0}}, idx};
			idx_to_slot = w[SLOT_BITS-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lptc_dir.sv =====
`default_nettype none

module lptc_dir
	import lptc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire dir_req_t req,
	output dir_res_t      res
);

	logic [ENTRIES-1:0] valid_q;
	tag_t               tag_q [ENTRIES];
	age_t               age_q [ENTRIES];

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] found_oh;
	logic [ENTRIES-1:0] free_oh;
	logic [ENTRIES-1:0] oldest;
	logic [ENTRIES-1:0] victim_oh;
	logic [ENTRIES-1:0] fill_oh;
	logic [ENTRIES-1:0] age0;
	logic               found;
	logic               full;
	logic               do_hit;
	logic               do_insert;
	age_t               hit_age;
	tag_t               victim_tag;

	function automatic idx_t enc(input logic [ENTRIES-1:0] oh);
		idx_t r;
		begin
			r = '0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (oh[i]) r = r | idx_t'(i);
			end
			enc = r;
		end
	endfunction

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_q[i] && (tag_q[i] == req.tag);
			oldest[i] = valid_q[i] && (age_q[i] == age_t'(ENTRIES - 1));
			age0[i]   = valid_q[i] && (age_q[i] == '0);
		end
	end

	// Lowest set bit of each request vector.
	assign found_oh  = match & (~match + 1'b1);
	assign free_oh   = ~valid_q & (valid_q + 1'b1);
	assign victim_oh = oldest & (~oldest + 1'b1);
	assign found     = |match;
	assign full      = &valid_q;
	assign fill_oh   = full ? victim_oh : free_oh;
	assign do_hit    = req.valid && found;
	assign do_insert = req.valid && !found && (req.opcode == OP_INSERT);

	always_comb begin
		hit_age    = '0;
		victim_tag = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (found_oh[i]) hit_age = hit_age | age_q[i];
			if (victim_oh[i]) victim_tag = victim_tag | tag_q[i];
		end
	end

	always_comb begin
		res = '0;
		if (do_hit) begin
			res.hit  = 1'b1;
			res.slot = enc(found_oh);
		end else if (do_insert) begin
			res.slot     = enc(fill_oh);
			res.ev_valid = full;
			res.ev_tag   = full ? victim_tag : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) age_q[i] <= '0;
		end else if (do_hit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (found_oh[i]) begin
					age_q[i] <= '0;
				end else if (valid_q[i] && age_q[i] < hit_age) begin
					age_q[i] <= age_q[i] + 1'b1;
				end
			end
		end else if (do_insert) begin
			valid_q <= valid_q | fill_oh;
			for (int i = 0; i < ENTRIES; i++) begin
				if (fill_oh[i]) begin
					age_q[i] <= '0;
				end else if (valid_q[i]) begin
					age_q[i] <= age_q[i] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (do_insert && fill_oh[i]) tag_q[i] <= req.tag;
		end
	end

	// Inserts happen only on a miss, so valid tags never repeat.
	a_unique_tags: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("two valid entries hold the same tag");

	a_one_newest: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(age0))
		else $error("more than one entry is most recent");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		res.ev_valid |-> (full && $onehot(victim_oh) && !res.hit))
		else $error("eviction without a single oldest entry in a full cache");

	a_valid_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((valid_q & $past(valid_q)) == $past(valid_q)))
		else $error("a valid mark was lost");

	a_insert_newest: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> (age0 == $past(fill_oh)))
		else $error("inserted entry is not the only most recent one");

endmodule

`default_nettype wire

// ===== rtl/lru_page_tag_cache.sv =====
// Channel   Handshake          Fields
// command   start / busy       opcode, page_num
// result    done (strobe)      hit, slot, evicted_valid, evicted_page
//
// A command is taken at every edge with start high; busy is always low, so one
// command per cycle is sustained. Its result passes first through the input register,
// then through the tag compare and age update into the result register, with done high
// for exactly one cycle. Reset clears all valid marks and ages at once; no clearing
// pass is needed. The receiver cannot stall results.
`default_nettype none

module lru_page_tag_cache
	import lptc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 opcode,
	input  wire logic [PAGE_BITS-1:0] page_num,
	output logic                      done,
	output logic                      hit,
	output logic [SLOT_BITS-1:0]      slot,
	output logic                      evicted_valid,
	output logic [PAGE_BITS-1:0]      evicted_page
);

	logic     valid_s1;
	logic     opcode_s1;
	tag_t     tag_s1;
	dir_req_t req;
	dir_res_t res;

	logic                 done_q;
	logic                 hit_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		opcode_s1  <= opcode;
		tag_s1     <= page_to_tag(page_num);
		hit_q      <= res.hit;
		slot_q     <= idx_to_slot(res.slot);
		ev_valid_q <= res.ev_valid;
		ev_page_q  <= tag_to_page(res.ev_tag);
	end

	always_comb begin
		req.valid  = valid_s1;
		req.opcode = opcode_s1;
		req.tag    = tag_s1;
	end

	lptc_dir u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	assign done          = done_q;
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;

endmodule

`default_nettype wire

// ===== verif/lru_page_tag_cache_test.sv =====
`timescale 1ns / 100ps

module lru_page_tag_cache_test;
	import lptc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int ITEMS_PER_RUN = 650;
	localparam int POOL_SIZE    = 12;

	typedef struct packed {
		logic                 hit;
		logic [SLOT_BITS-1:0] slot;
		logic                 ev_valid;
		logic [PAGE_BITS-1:0] ev_page;
	} dir_reply_t;

	// Tracks the directory contents and the replies that are still owed.
	class lru_directory_tracker;
		bit         held[ENTRIES];
		tag_t       held_tag[ENTRIES];
		int         rank[ENTRIES];
		dir_reply_t owed_replies[$];
		int         errors;
		int         n_hits;
		int         n_misses;
		int         n_fills;
		int         n_evictions;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				held[i] = 0;
				held_tag[i] = '0;
				rank[i] = 0;
			end
			errors = 0;
			n_hits = 0;
			n_misses = 0;
			n_fills = 0;
			n_evictions = 0;
		endfunction

		function int pending();
			return owed_replies.size();
		endfunction

		// Works out the reply to one accepted command and updates the directory.
		function void note_command(logic op, logic [PAGE_BITS-1:0] page);
			int         found;
			int         free_slot;
			int         victim;
			int         vrank;
			int         s;
			int         old_rank;
			tag_t       t;
			dir_reply_t r;
			found = -1;
			free_slot = -1;
			victim = -1;
			vrank = 0;
			t = tag_t'(page);
			r = '0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (held[i]) begin
					if (found < 0 && held_tag[i] == t)
						found = i;
					if (victim < 0 || rank[i] > vrank) begin
						victim = i;
						vrank = rank[i];
					end
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (found >= 0) begin
				old_rank = rank[found];
				for (int i = 0; i < ENTRIES; i++)
					if (held[i] && i != found && rank[i] < old_rank)
						rank[i]++;
				rank[found] = 0;
				r.hit = 1'b1;
				r.slot = SLOT_BITS'(found);
				n_hits++;
			end else if (op == OP_INSERT) begin
				if (free_slot >= 0) begin
					s = free_slot;
					n_fills++;
				end else begin
					s = (victim < 0) ? 0 : victim;
					r.ev_valid = 1'b1;
					r.ev_page = PAGE_BITS'(held_tag[s]);
					held[s] = 0;
					n_evictions++;
				end
				for (int i = 0; i < ENTRIES; i++)
					if (held[i] && rank[i] < 255)
						rank[i]++;
				held[s] = 1;
				held_tag[s] = t;
				rank[s] = 0;
				r.slot = SLOT_BITS'(s);
			end else begin
				n_misses++;
			end
			owed_replies.push_back(r);
		endfunction

		function void check_result(logic hit, logic [SLOT_BITS-1:0] slot, logic ev_valid,
				logic [PAGE_BITS-1:0] ev_page);
			dir_reply_t e;
			if (owed_replies.size() == 0) begin
				$error("result transfer with no command outstanding");
				errors++;
				return;
			end
			e = owed_replies.pop_front();
			if (hit !== e.hit) begin
				$error("hit: expected %0d, actual %0d", e.hit, hit);
				errors++;
			end
			if (slot !== e.slot) begin
				$error("slot: expected %0d, actual %0d", e.slot, slot);
				errors++;
			end
			if (ev_valid !== e.ev_valid) begin
				$error("evicted_valid: expected %0d, actual %0d", e.ev_valid, ev_valid);
				errors++;
			end
			if (ev_page !== e.ev_page) begin
				$error("evicted_page: expected 0x%04h, actual 0x%04h", e.ev_page, ev_page);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 opcode;
	logic [PAGE_BITS-1:0] page_num;
	logic                 done;
	logic                 hit;
	logic [SLOT_BITS-1:0] slot;
	logic                 evicted_valid;
	logic [PAGE_BITS-1:0] evicted_page;

	lru_directory_tracker dir_track = new();
	int                   cycles = 0;
	int                   n_sent;
	logic [PAGE_BITS-1:0] page_pool[POOL_SIZE];

	lru_page_tag_cache u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.page_num(page_num),
		.done(done),
		.hit(hit),
		.slot(slot),
		.evicted_valid(evicted_valid),
		.evicted_page(evicted_page)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Transfers on both channels are taken here, with the values from before the edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else if (arst_n) begin
			if (start && !busy)
				dir_track.note_command(opcode, page_num);
			if (done)
				dir_track.check_result(hit, slot, evicted_valid, evicted_page);
		end
	end

	task automatic issue(input logic op, input logic [PAGE_BITS-1:0] page);
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		page_num <= page;
		do
			@(posedge clk);
		while (busy);
		n_sent++;
	endtask

	// The fields wander while start is low, so the block must ignore them.
	task automatic idle_cycle();
		@(negedge clk);
		start <= 1'b0;
		opcode <= 1'($urandom_range(1));
		page_num <= PAGE_BITS'($urandom);
	endtask

	task automatic drain();
		idle_cycle();
		while (dir_track.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_run(input int idle_pct);
		logic                 op;
		logic [PAGE_BITS-1:0] page;
		for (int i = 0; i < POOL_SIZE; i++)
			page_pool[i] = PAGE_BITS'($urandom);
		for (int n = 0; n < ITEMS_PER_RUN; n++) begin
			while ($urandom_range(99) < idle_pct)
				idle_cycle();
			op = 1'($urandom_range(1));
			if ($urandom_range(99) < 80)
				page = page_pool[$urandom_range(POOL_SIZE - 1)];
			else
				page = PAGE_BITS'($urandom);
			issue(op, page);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_LOOKUP;
		page_num = '0;
		n_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty directory, then two extreme pages, hits by both opcodes and a plain miss.
		issue(OP_LOOKUP, 16'h0000);
		issue(OP_INSERT, 16'h0000);
		issue(OP_INSERT, 16'hFFFF);
		issue(OP_LOOKUP, 16'hFFFF);
		issue(OP_LOOKUP, 16'h0000);
		issue(OP_INSERT, 16'hFFFF);
		issue(OP_LOOKUP, 16'h1234);
		// Fill the remaining slots, then force evictions of the oldest entries.
		issue(OP_INSERT, 16'h5555);
		issue(OP_INSERT, 16'hAAAA);
		issue(OP_INSERT, 16'h0001);
		issue(OP_INSERT, 16'h8000);
		issue(OP_INSERT, 16'h7FFF);
		issue(OP_INSERT, 16'h00FF);
		issue(OP_INSERT, 16'hFF00);
		issue(OP_LOOKUP, 16'h0000);
		issue(OP_INSERT, 16'h0000);
		issue(OP_LOOKUP, 16'h5555);
		issue(OP_INSERT, 16'h1234);
		issue(OP_INSERT, 16'hFFFF);
		issue(OP_LOOKUP, 16'hAAAA);
		drain();

		random_run(24);
		drain();
		random_run(84);
		drain();
		random_run(0);
		drain();
		repeat (4) @(posedge clk);

		$display("Sent %0d commands: %0d hits, %0d lookup misses, %0d fills, %0d evictions.",
			n_sent, dir_track.n_hits, dir_track.n_misses, dir_track.n_fills,
			dir_track.n_evictions);
		$display("Sender gaps of 24 and 84 percent and back-to-back traffic were all exercised.");
		if (dir_track.errors == 0 && dir_track.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
